// ===== src/blgn_pkg.sv =====
package blgn_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_CLOSE,
		ST_MEAN,
		ST_READ,
		ST_LOAD,
		ST_SCALE,
		ST_EMIT
	} blgn_state_t;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_CENTER = 2'd0;
	localparam logic [1:0] REG_LOW    = 2'd1;
	localparam logic [1:0] REG_HIGH   = 2'd2;
	localparam logic [1:0] REG_TARGET = 2'd3;

	// Register reset values
	localparam logic [7:0] CENTER_RST = 8'd127;
	localparam logic [7:0] LOW_RST    = 8'd20;
	localparam logic [7:0] HIGH_RST   = 8'd200;
	localparam logic [7:0] TARGET_RST = 8'd200;

	// Sample and accumulator widths
	localparam int SMP_W = 8;
	localparam int SUM_W = 14;
	localparam logic [SMP_W-1:0] SMP_MAX = 8'hFF;

	// Shared divider widths
	localparam int NUM_W = 16;
	localparam int DEN_W = 8;
	localparam int STEP_W = 4;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== src/blgn_div.sv =====
module blgn_div
	import blgn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [NUM_W-1:0]  quot_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0]    trial;
	logic              fits;
	logic [DEN_W:0]    diff;

	// One restoring step: shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// Control: run one step per cycle, flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a preceding run");

	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while running");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> !busy_q || step_q == '0)
		else $error("divider step count not cleared at start");

endmodule

// ===== src/block_level_gain_normalizer_unit.sv =====
// Collects a block of samples (one beat per cycle while collecting), then emits it.
// After the closing beat, the mean deviation is computed on the shared 16-step divider.
// Emission: each beat is read, loaded and emitted in turn; a scaled beat also waits on
// the shared radix-2 divider, one quotient bit per cycle.
// No new input beat is taken until the block has been fully emitted.
// Reset (arst_n low) clears the sequencer, counts and sum, and restores register defaults.
module block_level_gain_normalizer_unit
	import blgn_pkg::*;
#(
	parameter int MAX_BLOCK = 64
)
(
	input  logic             clk,
	input  logic             arst_n,
	// Input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [SMP_W-1:0] sample_in,
	input  logic             block_end,
	// Output channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [SMP_W-1:0] sample_out,
	output logic             last_out,
	// Configuration port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

	blgn_state_t state_q, state_d;

	logic [SMP_W-1:0] center_q, low_q, high_q, target_q;
	logic [SMP_W-1:0] mem [MAX_BLOCK];
	logic [SMP_W-1:0] rd_data_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [SMP_W-1:0] d_q;
	logic             scale_q;
	logic [SMP_W-1:0] out_data_q;
	logic             out_last_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic             in_acc, out_acc, cfg_wr;
	logic             closing, at_last;
	logic [SMP_W-1:0] dev;
	logic [SMP_W-1:0] mean;
	logic [SMP_W-1:0] distance;
	logic [NUM_W-1:0] prod;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign cfg_wr  = psel && penable && pwrite && pready;

	assign dev      = (sample_in >= center_q) ? sample_in - center_q : center_q - sample_in;
	assign closing  = block_end || (count_q == CNT_W'(MAX_BLOCK - 1));
	assign at_last  = (CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q;
	assign mean     = div_rsp.quot[SMP_W-1:0];
	assign distance = (mean >= center_q) ? mean - center_q : center_q - mean;
	assign prod     = NUM_W'(target_q) * NUM_W'(rd_data_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RST;
			low_q    <= LOW_RST;
			high_q   <= HIGH_RST;
			target_q <= TARGET_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_CENTER: center_q <= pwdata[SMP_W-1:0];
				REG_LOW:    low_q    <= pwdata[SMP_W-1:0];
				REG_HIGH:   high_q   <= pwdata[SMP_W-1:0];
				REG_TARGET: target_q <= pwdata[SMP_W-1:0];
				default:    ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[3:2])
			REG_CENTER: prdata = {24'd0, center_q};
			REG_LOW:    prdata = {24'd0, low_q};
			REG_HIGH:   prdata = {24'd0, high_q};
			REG_TARGET: prdata = {24'd0, target_q};
			default:    prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Sample store: write on accepted beats, registered read at the emit index
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem[count_q[IDX_W-1:0]] <= sample_in;
		end
		rd_data_q <= mem[rd_idx_q];
	end

	// Shared divider
	blgn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider requests
	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.num   = prod;
		div_req.den   = d_q;
		in_stall      = 1'b1;
		case (state_q)
			ST_COLLECT: begin
				in_stall = 1'b0;
				if (in_valid && closing) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'(sum_q);
				div_req.den   = DEN_W'(count_q);
				state_d       = ST_MEAN;
			end
			ST_MEAN: begin
				if (div_rsp.done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (scale_q) begin
					div_req.start = 1'b1;
					state_d       = ST_SCALE;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SCALE: begin
				if (div_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_acc) begin
					state_d = at_last ? ST_COLLECT : ST_READ;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	// Block count and deviation sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			if (in_acc) begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= sum_q + SUM_W'(dev);
			end
			if (state_q == ST_MEAN) begin
				rd_idx_q <= '0;
			end
			if (out_acc) begin
				if (at_last) begin
					count_q <= '0;
					sum_q   <= '0;
				end else begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
			end
		end
	end

	// Gain decision once the mean is known
	always_ff @(posedge clk) begin
		if (state_q == ST_MEAN && div_rsp.done) begin
			d_q     <= distance;
			scale_q <= (distance > low_q) && (distance < high_q);
		end
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_d == ST_EMIT && state_q != ST_EMIT) begin
			out_valid <= 1'b1;
		end else if (out_acc) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			out_data_q <= rd_data_q;
			out_last_q <= at_last;
		end
		if (state_q == ST_SCALE && div_rsp.done) begin
			out_data_q <= (div_rsp.quot > NUM_W'(SMP_MAX)) ? SMP_MAX
			                                               : div_rsp.quot[SMP_W-1:0];
		end
	end

	assign sample_out = out_data_q;
	assign last_out   = out_last_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("input taken while an output beat is pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCK))
		else $error("block count beyond maximum");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> CNT_W'(rd_idx_q) < count_q)
		else $error("emitting beyond the stored block");

	a_last_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_out |=> !in_stall && count_q == '0 && sum_q == '0)
		else $error("block not reopened after its last beat");

	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start && state_q == ST_LOAD |-> d_q != '0)
		else $error("scaling with zero distance");

endmodule

// ===== verif/blgn_checker.sv =====
module blgn_checker
	import blgn_pkg::*;
#(
	parameter int MAX_BLOCK = 64
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [SMP_W-1:0] sample_in,
	input  logic             block_end,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [SMP_W-1:0] sample_out,
	input  logic             last_out,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	input  logic             pready,
	output int               mismatch_count,
	output int               pending_beats,
	output int               beats_in,
	output int               beats_out,
	output int               blocks_scaled,
	output int               blocks_plain
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SMP_W-1:0] smp;
		logic             last;
	} out_beat_t;

	out_beat_t        expected_beats[$];
	logic [SMP_W-1:0] center_q, low_q, high_q, target_q;
	logic [SMP_W-1:0] block_buf [MAX_BLOCK];
	logic [SUM_W-1:0] dev_sum;
	int               fill;
	int               errs, n_in, n_out, n_scaled, n_plain;

	function automatic logic [SMP_W-1:0] abs_dist(input logic [SMP_W-1:0] a,
			input logic [SMP_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [SMP_W-1:0] gain_sample(input logic [SMP_W-1:0] s,
			input logic [SMP_W-1:0] tgt, input logic [SMP_W-1:0] distance);
		logic [NUM_W-1:0] prod;
		logic [NUM_W-1:0] quo;
		prod = {8'd0, tgt} * {8'd0, s};
		quo  = prod / {8'd0, distance};
		return (quo > {8'd0, SMP_MAX}) ? SMP_MAX : quo[SMP_W-1:0];
	endfunction

	// Close the collected block: pick gain or pass-through, queue every output beat
	task automatic close_block();
		logic [SUM_W-1:0] mean_full;
		logic [SMP_W-1:0] distance;
		logic             apply_gain;
		out_beat_t        beat;
		mean_full  = dev_sum / SUM_W'(fill);
		distance   = abs_dist(mean_full[SMP_W-1:0], center_q);
		apply_gain = (distance > low_q) && (distance < high_q);
		if (apply_gain)
			n_scaled++;
		else
			n_plain++;
		for (int k = 0; k < fill; k++) begin
			beat.smp  = apply_gain ? gain_sample(block_buf[k], target_q, distance)
			                       : block_buf[k];
			beat.last = (k == fill - 1);
			expected_beats.push_back(beat);
		end
		fill    = 0;
		dev_sum = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		out_beat_t got;
		out_beat_t want;
		if (!arst_n) begin
			expected_beats.delete();
			center_q = CENTER_RST;
			low_q    = LOW_RST;
			high_q   = HIGH_RST;
			target_q = TARGET_RST;
			dev_sum  = '0;
			fill     = 0;
			errs     = 0;
			n_in     = 0;
			n_out    = 0;
			n_scaled = 0;
			n_plain  = 0;
		end else begin
			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_CENTER: center_q = pwdata[SMP_W-1:0];
					REG_LOW:    low_q    = pwdata[SMP_W-1:0];
					REG_HIGH:   high_q   = pwdata[SMP_W-1:0];
					REG_TARGET: target_q = pwdata[SMP_W-1:0];
					default: ;
				endcase
			end

			// Collect input beat, close on the end flag or a full block
			if (in_valid && !in_stall) begin
				n_in++;
				block_buf[fill] = sample_in;
				fill++;
				dev_sum = dev_sum + SUM_W'(abs_dist(sample_in, center_q));
				if (block_end || fill == MAX_BLOCK)
					close_block();
			end

			// Compare output beat against the oldest expectation
			if (out_valid && !out_stall) begin
				n_out++;
				got.smp  = sample_out;
				got.last = last_out;
				if (expected_beats.size() == 0) begin
					if (errs < 10)
						$display("%0t: unexpected output beat sample_out=%0d last_out=%0b",
							$realtime, got.smp, got.last);
					errs++;
				end else begin
					want = expected_beats.pop_front();
					if (got.smp !== want.smp || got.last !== want.last) begin
						if (errs < 10)
							$display({"%0t: mismatch sample_out exp=%0d got=%0d,",
								" last_out exp=%0b got=%0b"},
								$realtime, want.smp, got.smp, want.last, got.last);
						errs++;
					end
				end
			end
		end
		mismatch_count <= errs;
		pending_beats  <= expected_beats.size();
		beats_in       <= n_in;
		beats_out      <= n_out;
		blocks_scaled  <= n_scaled;
		blocks_plain   <= n_plain;
	end

endmodule

// ===== verif/block_level_gain_normalizer_unit_tb.sv =====
module block_level_gain_normalizer_unit_tb;
	import blgn_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BLOCK    = 64;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES       = 8;
	localparam int PHASE_BEATS  = 16;
	localparam int N_DIRECTED   = 22;

	// Directed beats: bit 8 is the end flag, bits 7:0 the sample
	localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
		9'h100, 9'h1FF, 9'h17F,
		9'h000, 9'h0FF, 9'h07F, 9'h180,
		9'h0FF, 9'h0FF, 9'h000, 9'h000, 9'h1FF,
		9'h064, 9'h096, 9'h040, 9'h1BE,
		9'h001, 9'h002, 9'h0FE, 9'h0FD, 9'h080, 9'h17E
	};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [SMP_W-1:0] sample_in = '0;
	logic             block_end = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [SMP_W-1:0] sample_out;
	logic             last_out;
	logic             psel      = 1'b0;
	logic             penable   = 1'b0;
	logic             pwrite    = 1'b0;
	logic [3:0]       paddr     = '0;
	logic [31:0]      pwdata    = '0;
	logic [31:0]      prdata;
	logic             pready;

	int mismatch_count, pending_beats, beats_in, beats_out, blocks_scaled, blocks_plain;
	int idle_pct  = 0;
	int stall_pct = 0;
	int cycle_cnt = 0;
	int cur_center = 127;

	block_level_gain_normalizer_unit #(.MAX_BLOCK(MAX_BLOCK)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in), .block_end(block_end),
		.out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
		.last_out(last_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	blgn_checker #(.MAX_BLOCK(MAX_BLOCK)) i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in), .block_end(block_end),
		.out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
		.last_out(last_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.mismatch_count(mismatch_count), .pending_beats(pending_beats),
		.beats_in(beats_in), .beats_out(beats_out),
		.blocks_scaled(blocks_scaled), .blocks_plain(blocks_plain)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Stall the output side at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offer one input beat, idling first at random, and hold it until taken
	task automatic send_beat(input logic [SMP_W-1:0] s, input logic e);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		block_end <= e;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait until every queued output beat has come out
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_beats != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
		logic [23:0] junk;
		junk = 24'($urandom());
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {junk, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Program all four registers for a phase, extremes first, then random
	task automatic program_phase(input int p);
		logic [7:0] c, lo, hi, tg;
		case (p)
			0: begin c = 8'd127; lo = 8'd20;  hi = 8'd200; tg = 8'd200; end
			1: begin c = 8'd0;   lo = 8'd0;   hi = 8'd255; tg = 8'd255; end
			2: begin c = 8'd255; lo = 8'd0;   hi = 8'd255; tg = 8'd1;   end
			3: begin c = 8'd200; lo = 8'd10;  hi = 8'd150; tg = 8'd0;   end
			4: begin c = 8'd127; lo = 8'd100; hi = 8'd50;  tg = 8'd200; end
			5: begin c = 8'd64;  lo = 8'd255; hi = 8'd255; tg = 8'd128; end
			default: begin
				c  = 8'($urandom());
				lo = 8'($urandom_range(60));
				hi = 8'($urandom_range(255, 100));
				tg = 8'($urandom());
			end
		endcase
		cur_center = int'(c);
		apb_write(REG_CENTER, c);
		apb_write(REG_LOW, lo);
		apb_write(REG_HIGH, hi);
		apb_write(REG_TARGET, tg);
	endtask

	// Pick a sample whose shape depends on the block flavor
	function automatic logic [SMP_W-1:0] pick_sample(input int flavor,
			input logic [SMP_W-1:0] fixed);
		int v;
		case (flavor)
			0: v = $urandom_range(255);
			1: v = $urandom_range(1) ? $urandom_range(255, 240) : $urandom_range(15);
			2: begin
				v = cur_center + $urandom_range(16) - 8;
				if (v < 0) v = 0;
				if (v > 255) v = 255;
			end
			default: v = int'(fixed);
		endcase
		return v[SMP_W-1:0];
	endfunction

	task automatic send_random_block(input int len);
		int               flavor;
		logic [SMP_W-1:0] fixed;
		flavor = $urandom_range(3);
		fixed  = 8'($urandom());
		for (int k = 0; k < len; k++)
			send_beat(pick_sample(flavor, fixed), k == len - 1);
	endtask

	initial begin : stimulus
		int sent;
		int len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed blocks under reset register values
		for (int k = 0; k < N_DIRECTED; k++)
			send_beat(DIRECTED[k][7:0], DIRECTED[k][8]);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct <= 0;  end
				1: begin idle_pct = 87; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 87; end
				default: begin idle_pct = 24; stall_pct <= 24; end
			endcase
			program_phase(p);
			sent = 0;
			// Overlong run closes at the block limit, then a short tail follows
			if (p == 0) begin
				send_random_block(MAX_BLOCK + 3);
				sent += MAX_BLOCK + 3;
			end
			if (p == 5) begin
				send_random_block(MAX_BLOCK);
				sent += MAX_BLOCK;
			end
			while (sent < PHASE_BEATS) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
				send_random_block(len);
				sent += len;
			end
			settle();
		end

		$display("Run covered %0d input beats and %0d output beats over %0d register settings",
			beats_in, beats_out, PHASES + 1);
		$display("Blocks with gain applied: %0d, blocks passed through: %0d",
			blocks_scaled, blocks_plain);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
